// ===== sv/ddpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddpd_pkg
// Shared types and constants of the differential-drive base PD torque block.
// ----------------------------------------------------------------------------
package ddpd_pkg;

    // fixed-point constants, Q16.16 unless noted
    localparam logic [19:0] PI_Q16           = 20'd205887;
    localparam logic [19:0] TWO_PI_Q16       = 20'd411775;
    localparam logic [29:0] TURN_PER_RAD_Q32 = 30'd683565276;
    localparam logic [29:0] CORDIC_GAIN_Q30  = 30'd652032874;
    localparam int          CORDIC_STEPS     = 30;

    // pipeline stage map
    localparam int ST_IN     = 0;
    localparam int ST_ANGLE  = 1;
    localparam int ST_QUANT  = 2;
    localparam int ST_ITER0  = 3;
    localparam int ST_MAP    = ST_ITER0 + CORDIC_STEPS;
    localparam int ST_PROJ   = ST_MAP + 1;
    localparam int ST_ERR    = ST_PROJ + 1;
    localparam int ST_GAIN   = ST_ERR + 1;
    localparam int ST_LAW    = ST_GAIN + 1;
    localparam int ST_MIX    = ST_LAW + 1;
    localparam int ST_OUT    = ST_MIX + 1;
    localparam int NUM_STAGES = ST_OUT + 1;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_KP_TRANSLATE         = 3'd0,
        REG_KD_TRANSLATE         = 3'd1,
        REG_PASSIVE_KD_TRANSLATE = 3'd2,
        REG_KP_ROTATE            = 3'd3,
        REG_KD_ROTATE            = 3'd4,
        REG_PASSIVE_KD_ROTATE    = 3'd5,
        REG_ACTUATE_ENABLE       = 3'd6,
        REG_HALF_INVERSE_AXLE    = 3'd7
    } cfg_index_t;

    // gain set seen by the control law
    typedef struct packed {
        logic [31:0] kp_translate;
        logic [31:0] kd_translate;
        logic [31:0] passive_kd_translate;
        logic [31:0] kp_rotate;
        logic [31:0] kd_rotate;
        logic [31:0] passive_kd_rotate;
        logic        actuate_enable;
        logic [31:0] half_inverse_axle;
    } cfg_t;

    // errors and velocities travelling beside the trig pipeline
    typedef struct packed {
        logic signed [32:0] err_x;
        logic signed [32:0] err_y;
        logic signed [31:0] speed_x;
        logic signed [31:0] speed_y;
        logic signed [31:0] turn_rate;
        logic signed [19:0] head_err;
    } side_t;

    // cordic arctangent table, binary angle units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input int unsigned step);
        logic [31:0] val;
        unique case (step)
            0:  val = 32'd536870912;
            1:  val = 32'd316933406;
            2:  val = 32'd167458907;
            3:  val = 32'd85004756;
            4:  val = 32'd42667331;
            5:  val = 32'd21354465;
            6:  val = 32'd10679838;
            7:  val = 32'd5340245;
            8:  val = 32'd2670163;
            9:  val = 32'd1335087;
            10: val = 32'd667544;
            11: val = 32'd333772;
            12: val = 32'd166886;
            13: val = 32'd83443;
            14: val = 32'd41722;
            15: val = 32'd20861;
            16: val = 32'd10430;
            17: val = 32'd5215;
            18: val = 32'd2608;
            19: val = 32'd1304;
            20: val = 32'd652;
            21: val = 32'd326;
            22: val = 32'd163;
            23: val = 32'd81;
            24: val = 32'd41;
            25: val = 32'd20;
            26: val = 32'd10;
            27: val = 32'd5;
            28: val = 32'd3;
            29: val = 32'd1;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

endpackage

// ===== sv/ddpd_pipe_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddpd_pipe_ctrl
// Valid bits and load enables of the pipeline; empty stages close up.
// ----------------------------------------------------------------------------
module ddpd_pipe_ctrl (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [ddpd_pkg::NUM_STAGES-1:0]    stage_en
);

    localparam int N = ddpd_pkg::NUM_STAGES;

    logic [N-1:0] valid_reg;

    // a stage loads when empty or when its successor loads
    assign stage_en[N-1] = !valid_reg[N-1] || out_ready;
    genvar gi;
    generate
        for (gi = 0; gi < N - 1; gi++) begin : g_en
            assign stage_en[gi] = !valid_reg[gi] || stage_en[gi+1];
        end
    endgenerate

    // valid bits move with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_en[0]) begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < N; i++) begin
                if (stage_en[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign in_ready  = stage_en[0];
    assign out_valid = valid_reg[N-1];

    // a waiting result is held
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[N-1] && !out_ready |=> valid_reg[N-1])
        else $error("result dropped while stalled");

    // an empty first stage always takes an item
    a_in_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg[0] |-> in_ready)
        else $error("input blocked with empty first stage");

    // a full stalled pipeline accepts nothing
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (&valid_reg) && !out_ready |-> !in_ready)
        else $error("item accepted into full pipeline");

endmodule

// ===== sv/ddpd_trig.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddpd_trig
// Heading to binary angle, quantisation and a 30-stage cordic for cos and sin.
// ----------------------------------------------------------------------------
module ddpd_trig #(
    parameter int TRIG_TABLE_BITS = 10
) (
    input  logic                            aclk,
    input  logic [ddpd_pkg::NUM_STAGES-1:0] stage_en,
    input  logic signed [18:0]              heading,
    output logic signed [17:0]              cos_q16,
    output logic signed [17:0]              sin_q16
);

    localparam int STEPS = ddpd_pkg::CORDIC_STEPS;
    localparam int SHIFT = 32 - TRIG_TABLE_BITS;
    localparam logic [31:0] HALF_STEP = 32'(64'd1 << (SHIFT - 1));

    logic signed [49:0] prod_reg;
    logic signed [33:0] x_reg [0:STEPS];
    logic signed [33:0] y_reg [0:STEPS];
    logic signed [33:0] z_reg [0:STEPS];
    logic [1:0]         quad_reg [0:STEPS];
    logic signed [17:0] cos_reg;
    logic signed [17:0] sin_reg;

    logic signed [49:0]          prod_rnd;
    logic [31:0]                 bin_angle;
    logic [31:0]                 angle_rnd;
    logic [TRIG_TABLE_BITS-1:0]  idx;

    // heading in radians times turns per radian
    always_ff @(posedge aclk) begin
        if (stage_en[ddpd_pkg::ST_ANGLE]) begin
            prod_reg <= heading * $signed({1'b0, ddpd_pkg::TURN_PER_RAD_Q32});
        end
    end

    // round to binary angle, then to the nearest table step
    always_comb begin
        prod_rnd  = prod_reg + 50'sd32768;
        bin_angle = prod_rnd[47:16];
        angle_rnd = bin_angle + HALF_STEP;
        idx       = angle_rnd[31:SHIFT];
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ddpd_pkg::ST_QUANT]) begin
            x_reg[0]    <= $signed({4'b0000, ddpd_pkg::CORDIC_GAIN_Q30});
            y_reg[0]    <= '0;
            z_reg[0]    <= $signed({4'b0000, idx[TRIG_TABLE_BITS-3:0], {SHIFT{1'b0}}});
            quad_reg[0] <= idx[TRIG_TABLE_BITS-1:TRIG_TABLE_BITS-2];
        end
    end

    // one rotation step per stage
    genvar gi;
    generate
        for (gi = 0; gi < STEPS; gi++) begin : g_iter
            localparam logic signed [33:0] ATAN = $signed({2'b00, ddpd_pkg::atan_turn(gi)});
            always_ff @(posedge aclk) begin
                if (stage_en[ddpd_pkg::ST_ITER0 + gi]) begin
                    if (!z_reg[gi][33]) begin
                        x_reg[gi+1] <= x_reg[gi] - (y_reg[gi] >>> gi);
                        y_reg[gi+1] <= y_reg[gi] + (x_reg[gi] >>> gi);
                        z_reg[gi+1] <= z_reg[gi] - ATAN;
                    end else begin
                        x_reg[gi+1] <= x_reg[gi] + (y_reg[gi] >>> gi);
                        y_reg[gi+1] <= y_reg[gi] - (x_reg[gi] >>> gi);
                        z_reg[gi+1] <= z_reg[gi] + ATAN;
                    end
                    quad_reg[gi+1] <= quad_reg[gi];
                end
            end
        end
    endgenerate

    // round to signed Q1.16 and map the quadrant
    logic signed [33:0] x_rnd;
    logic signed [33:0] y_rnd;
    logic signed [17:0] xs;
    logic signed [17:0] ys;
    always_comb begin
        x_rnd = (x_reg[STEPS] + 34'sd8192) >>> 14;
        y_rnd = (y_reg[STEPS] + 34'sd8192) >>> 14;
        xs    = x_rnd[17:0];
        ys    = y_rnd[17:0];
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ddpd_pkg::ST_MAP]) begin
            unique case (quad_reg[STEPS])
                2'd0: begin
                    cos_reg <= xs;
                    sin_reg <= ys;
                end
                2'd1: begin
                    cos_reg <= -ys;
                    sin_reg <= xs;
                end
                2'd2: begin
                    cos_reg <= -xs;
                    sin_reg <= -ys;
                end
                default: begin
                    cos_reg <= ys;
                    sin_reg <= -xs;
                end
            endcase
        end
    end

    assign cos_q16 = cos_reg;
    assign sin_q16 = sin_reg;

endmodule

// ===== sv/ddpd_law.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddpd_law
// Projection onto the heading, PD laws and the wheel mix, six stages.
// ----------------------------------------------------------------------------
module ddpd_law (
    input  logic                            aclk,
    input  logic [ddpd_pkg::NUM_STAGES-1:0] stage_en,
    input  ddpd_pkg::cfg_t                  cfg,
    input  ddpd_pkg::side_t                 side,
    input  logic signed [17:0]              cos_q16,
    input  logic signed [17:0]              sin_q16,
    output logic signed [31:0]              left_torque,
    output logic signed [31:0]              right_torque
);

    localparam logic signed [66:0] MAX32 = 67'sd2147483647;
    localparam logic signed [66:0] MIN32 = -67'sd2147483648;

    // projection products
    logic signed [50:0] pex_reg, pey_reg, pvx_reg, pvy_reg;
    logic signed [19:0] herr_p_reg, herr_e_reg;
    logic signed [32:0] negw_p_reg, negw_e_reg;
    always_ff @(posedge aclk) begin
        if (stage_en[ddpd_pkg::ST_PROJ]) begin
            pex_reg    <= side.err_x * cos_q16;
            pey_reg    <= side.err_y * sin_q16;
            pvx_reg    <= side.speed_x * cos_q16;
            pvy_reg    <= side.speed_y * sin_q16;
            herr_p_reg <= side.head_err;
            negw_p_reg <= -{side.turn_rate[31], side.turn_rate};
        end
    end

    // sum, round and saturate
    function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
        logic signed [31:0] r;
        if (v > MAX32) begin
            r = 32'sh7fffffff;
        end else if (v < MIN32) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    logic signed [66:0] te_sum, tv_sum;
    always_comb begin
        te_sum = (67'(pex_reg) + 67'(pey_reg) + 67'sd32768) >>> 16;
        tv_sum = (67'(pvx_reg) + 67'(pvy_reg) + 67'sd32768) >>> 16;
    end

    logic signed [31:0] te_reg, tv_reg;
    always_ff @(posedge aclk) begin
        if (stage_en[ddpd_pkg::ST_ERR]) begin
            te_reg     <= sat32(te_sum);
            tv_reg     <= sat32(tv_sum);
            herr_e_reg <= herr_p_reg;
            negw_e_reg <= negw_p_reg;
        end
    end

    // gain products; passive mode zeroes the stiffness terms
    logic [31:0] ga, gb, gc, gd;
    always_comb begin
        if (cfg.actuate_enable) begin
            ga = cfg.kp_translate;
            gb = cfg.kd_translate;
            gc = cfg.kp_rotate;
            gd = cfg.kd_rotate;
        end else begin
            ga = '0;
            gb = cfg.passive_kd_translate;
            gc = '0;
            gd = cfg.passive_kd_rotate;
        end
    end

    logic signed [64:0] pa_reg, pb_reg;
    logic signed [52:0] pc_reg;
    logic signed [65:0] pd_reg;
    always_ff @(posedge aclk) begin
        if (stage_en[ddpd_pkg::ST_GAIN]) begin
            pa_reg <= $signed({1'b0, ga}) * te_reg;
            pb_reg <= $signed({1'b0, gb}) * tv_reg;
            pc_reg <= $signed({1'b0, gc}) * herr_e_reg;
            pd_reg <= $signed({1'b0, gd}) * negw_e_reg;
        end
    end

    // force and moment
    logic signed [66:0] fx_sum, mz_sum;
    always_comb begin
        fx_sum = ((67'(pa_reg) + 67'sd32768) >>> 16) - ((67'(pb_reg) + 67'sd32768) >>> 16);
        mz_sum = ((67'(pc_reg) + 67'sd32768) >>> 16) + ((67'(pd_reg) + 67'sd32768) >>> 16);
    end

    logic signed [31:0] fx_reg, mz_reg;
    always_ff @(posedge aclk) begin
        if (stage_en[ddpd_pkg::ST_LAW]) begin
            fx_reg <= sat32(fx_sum);
            mz_reg <= sat32(mz_sum);
        end
    end

    // half force and axle product
    logic signed [32:0] fx_inc;
    logic signed [32:0] half_reg;
    logic signed [64:0] mix_reg;
    always_comb begin
        fx_inc = {fx_reg[31], fx_reg} + 33'sd1;
    end
    always_ff @(posedge aclk) begin
        if (stage_en[ddpd_pkg::ST_MIX]) begin
            half_reg <= fx_inc >>> 1;
            mix_reg  <= $signed({1'b0, cfg.half_inverse_axle}) * mz_reg;
        end
    end

    // wheel torques
    logic signed [66:0] mix_rnd;
    always_comb begin
        mix_rnd = (67'(mix_reg) + 67'sd32768) >>> 16;
    end

    logic signed [31:0] left_reg, right_reg;
    always_ff @(posedge aclk) begin
        if (stage_en[ddpd_pkg::ST_OUT]) begin
            left_reg  <= sat32(67'(half_reg) - mix_rnd);
            right_reg <= sat32(67'(half_reg) + mix_rnd);
        end
    end

    assign left_torque  = left_reg;
    assign right_torque = right_reg;

endmodule

// ===== sv/diff_drive_base_pd_torque.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diff_drive_base_pd_torque
// Differential-drive base PD controller giving left and right wheel torques.
//
//  channel   direction  payload                         handshake
//  s_        in         pose, target, velocity, 264 b   s_tvalid / s_tready
//  m_        out        left, right torque, 64 b        m_tvalid / m_tready
//  cfg_      in         gain register write             cfg_we
//
// One item per cycle sustained while m_tready is high; most stages are the 30-step cordic.
// Reset clears the valid bits and loads the gain registers with their defaults.
// A stall at m_ holds the result; empty stages keep filling, so s_tready
// drops only once every stage holds an item.
// ----------------------------------------------------------------------------
module diff_drive_base_pd_torque #(
    parameter int TRIG_TABLE_BITS = 10
) (
    input  logic         aclk,
    input  logic         aresetn,
    // target_x, target_y, target_heading, pose_x, pose_y, pose_heading,
    // speed_x, speed_y, turn_rate, zero pad
    input  logic [263:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // left_wheel_torque, right_wheel_torque
    output logic [63:0]  m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);

    localparam int N = ddpd_pkg::NUM_STAGES;

    logic [N-1:0]    stage_en;
    ddpd_pkg::cfg_t  cfg_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kp_translate         <= 32'd6553600;
            cfg_reg.kd_translate         <= 32'd1769472;
            cfg_reg.passive_kd_translate <= 32'd131072;
            cfg_reg.kp_rotate            <= 32'd6553600;
            cfg_reg.kd_rotate            <= 32'd786432;
            cfg_reg.passive_kd_rotate    <= 32'd65536;
            cfg_reg.actuate_enable       <= 1'b1;
            cfg_reg.half_inverse_axle    <= 32'd65536;
        end else if (cfg_we) begin
            unique case (ddpd_pkg::cfg_index_t'(cfg_index))
                ddpd_pkg::REG_KP_TRANSLATE:         cfg_reg.kp_translate <= cfg_wdata;
                ddpd_pkg::REG_KD_TRANSLATE:         cfg_reg.kd_translate <= cfg_wdata;
                ddpd_pkg::REG_PASSIVE_KD_TRANSLATE: cfg_reg.passive_kd_translate <= cfg_wdata;
                ddpd_pkg::REG_KP_ROTATE:            cfg_reg.kp_rotate <= cfg_wdata;
                ddpd_pkg::REG_KD_ROTATE:            cfg_reg.kd_rotate <= cfg_wdata;
                ddpd_pkg::REG_PASSIVE_KD_ROTATE:    cfg_reg.passive_kd_rotate <= cfg_wdata;
                ddpd_pkg::REG_ACTUATE_ENABLE:       cfg_reg.actuate_enable <= cfg_wdata[0];
                default:                            cfg_reg.half_inverse_axle <= cfg_wdata;
            endcase
        end
    end

    ddpd_pipe_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stage_en  (stage_en)
    );

    // input register
    logic signed [31:0] tx_reg, ty_reg, px_reg, py_reg, vx_reg, vy_reg, w_reg;
    logic signed [18:0] th_reg, ph_reg;
    always_ff @(posedge aclk) begin
        if (stage_en[ddpd_pkg::ST_IN]) begin
            tx_reg <= s_tdata[31:0];
            ty_reg <= s_tdata[63:32];
            th_reg <= s_tdata[82:64];
            px_reg <= s_tdata[114:83];
            py_reg <= s_tdata[146:115];
            ph_reg <= s_tdata[165:147];
            vx_reg <= s_tdata[197:166];
            vy_reg <= s_tdata[229:198];
            w_reg  <= s_tdata[261:230];
        end
    end

    // position errors and heading error with one wrap
    logic signed [19:0] herr_raw, herr;
    always_comb begin
        herr_raw = 20'(th_reg) - 20'(ph_reg);
        if (herr_raw > $signed(ddpd_pkg::PI_Q16)) begin
            herr = herr_raw - $signed(ddpd_pkg::TWO_PI_Q16);
        end else if (herr_raw < -$signed(ddpd_pkg::PI_Q16)) begin
            herr = herr_raw + $signed(ddpd_pkg::TWO_PI_Q16);
        end else begin
            herr = herr_raw;
        end
    end

    // side data delayed alongside the cordic
    ddpd_pkg::side_t side_reg [ddpd_pkg::ST_ANGLE:ddpd_pkg::ST_MAP];
    always_ff @(posedge aclk) begin
        if (stage_en[ddpd_pkg::ST_ANGLE]) begin
            side_reg[ddpd_pkg::ST_ANGLE].err_x     <= 33'(tx_reg) - 33'(px_reg);
            side_reg[ddpd_pkg::ST_ANGLE].err_y     <= 33'(ty_reg) - 33'(py_reg);
            side_reg[ddpd_pkg::ST_ANGLE].speed_x   <= vx_reg;
            side_reg[ddpd_pkg::ST_ANGLE].speed_y   <= vy_reg;
            side_reg[ddpd_pkg::ST_ANGLE].turn_rate <= w_reg;
            side_reg[ddpd_pkg::ST_ANGLE].head_err  <= herr;
        end
    end
    genvar gi;
    generate
        for (gi = ddpd_pkg::ST_ANGLE + 1; gi <= ddpd_pkg::ST_MAP; gi++) begin : g_side
            always_ff @(posedge aclk) begin
                if (stage_en[gi]) begin
                    side_reg[gi] <= side_reg[gi-1];
                end
            end
        end
    endgenerate

    logic signed [17:0] cos_q16, sin_q16;
    ddpd_trig #(
        .TRIG_TABLE_BITS (TRIG_TABLE_BITS)
    ) u_trig (
        .aclk     (aclk),
        .stage_en (stage_en),
        .heading  (ph_reg),
        .cos_q16  (cos_q16),
        .sin_q16  (sin_q16)
    );

    logic signed [31:0] left_torque, right_torque;
    ddpd_law u_law (
        .aclk         (aclk),
        .stage_en     (stage_en),
        .cfg          (cfg_reg),
        .side         (side_reg[ddpd_pkg::ST_MAP]),
        .cos_q16      (cos_q16),
        .sin_q16      (sin_q16),
        .left_torque  (left_torque),
        .right_torque (right_torque)
    );

    assign m_tdata = {right_torque, left_torque};

endmodule

// ===== bench/diff_drive_base_pd_torque_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diff_drive_base_pd_torque_test
// Drives pose, target and velocity items through the base PD torque block
// under random idling on both sides, predicts the wheel torques with an
// independent fixed-point model, and compares each result in order.
// ----------------------------------------------------------------------------
module diff_drive_base_pd_torque_test;

    localparam int TRIG_BITS   = 10;
    localparam int LATENCY     = 40;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [31:0] turn_rate;
        logic signed [31:0] speed_y;
        logic signed [31:0] speed_x;
        logic signed [18:0] pose_heading;
        logic signed [31:0] pose_y;
        logic signed [31:0] pose_x;
        logic signed [18:0] target_heading;
        logic signed [31:0] target_y;
        logic signed [31:0] target_x;
    } pose_item_t;

    typedef struct packed {
        logic signed [31:0] right;
        logic signed [31:0] left;
    } torque_t;

    // gain set held by the predictor
    typedef struct {
        logic [31:0] kp_t, kd_t, pkd_t, kp_r, kd_r, pkd_r, hia;
        logic        act;
    } gains_t;

    // ------------------------------------------------------------------
    // torque predictor and in-order result store
    // ------------------------------------------------------------------
    class torque_scoreboard;
        gains_t  g;
        torque_t pending[$];
        int      fails;

        function new();
            g.kp_t = 32'd6553600; g.kd_t = 32'd1769472; g.pkd_t = 32'd131072;
            g.kp_r = 32'd6553600; g.kd_r = 32'd786432;  g.pkd_r = 32'd65536;
            g.act = 1'b1; g.hia = 32'd65536;
            fails = 0;
        endfunction

        function void set_reg(ddpd_pkg::cfg_index_t idx, logic [31:0] v);
            case (idx)
                ddpd_pkg::REG_KP_TRANSLATE:         g.kp_t = v;
                ddpd_pkg::REG_KD_TRANSLATE:         g.kd_t = v;
                ddpd_pkg::REG_PASSIVE_KD_TRANSLATE: g.pkd_t = v;
                ddpd_pkg::REG_KP_ROTATE:            g.kp_r = v;
                ddpd_pkg::REG_KD_ROTATE:            g.kd_r = v;
                ddpd_pkg::REG_PASSIVE_KD_ROTATE:    g.pkd_r = v;
                ddpd_pkg::REG_ACTUATE_ENABLE:       g.act = v[0];
                ddpd_pkg::REG_HALF_INVERSE_AXLE:    g.hia = v;
                default: ;
            endcase
        endfunction

        // arithmetic shift is floor division for signed values
        static function longint rnd16(longint p);
            return (p + 64'sd32768) >>> 16;
        endfunction

        static function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        static function void sin_cos(longint h, output longint c, output longint s);
            longint x, y, z, dx, dy;
            logic [31:0] ang, qa;
            logic [63:0] idx;
            logic [1:0] quad;
            ang = 32'(rnd16(h * 64'sd683565276));
            idx = ((64'(ang) + (64'd1 << (31 - TRIG_BITS))) >> (32 - TRIG_BITS))
                  & ((64'd1 << TRIG_BITS) - 1);
            qa = 32'(idx << (32 - TRIG_BITS));
            quad = qa[31:30];
            x = 64'sd652032874; y = 0; z = longint'(qa[29:0]);
            for (int i = 0; i < ddpd_pkg::CORDIC_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= longint'(ddpd_pkg::atan_turn(i));
                end else begin
                    x += dx; y -= dy; z += longint'(ddpd_pkg::atan_turn(i));
                end
            end
            x = (x + 8192) >>> 14;
            y = (y + 8192) >>> 14;
            case (quad)
                2'd0: begin c = x;  s = y;  end
                2'd1: begin c = -y; s = x;  end
                2'd2: begin c = -x; s = -y; end
                default: begin c = y; s = -x; end
            endcase
        endfunction

        function void note_item(pose_item_t it);
            longint c, s, te, tv, herr, fx, mz, half, mix;
            torque_t r;
            sin_cos(longint'(it.pose_heading), c, s);
            te = clip32(rnd16((longint'(it.target_x) - it.pose_x) * c
                              + (longint'(it.target_y) - it.pose_y) * s));
            tv = clip32(rnd16(longint'(it.speed_x) * c + longint'(it.speed_y) * s));
            herr = longint'(it.target_heading) - longint'(it.pose_heading);
            if (herr > 205887) herr -= 411775;
            else if (herr < -205887) herr += 411775;
            if (g.act) begin
                fx = rnd16(longint'(g.kp_t) * te) - rnd16(longint'(g.kd_t) * tv);
                mz = rnd16(longint'(g.kp_r) * herr) + rnd16(longint'(g.kd_r) * -it.turn_rate);
            end else begin
                fx = -rnd16(longint'(g.pkd_t) * tv);
                mz = rnd16(longint'(g.pkd_r) * -longint'(it.turn_rate));
            end
            fx = clip32(fx);
            mz = clip32(mz);
            half = (fx + 1) >>> 1;
            mix = rnd16(longint'(g.hia) * mz);
            r.left = 32'(clip32(half - mix));
            r.right = 32'(clip32(half + mix));
            pending.push_back(r);
        endfunction

        function void check_result(torque_t got);
            torque_t want;
            if (pending.size() == 0) begin
                fails++;
                if (fails <= 10) $display("result with nothing pending: %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.left !== want.left || got.right !== want.right) begin
                fails++;
                if (fails <= 10)
                    $display("torque mismatch: left exp %0d got %0d, right exp %0d got %0d",
                             want.left, got.left, want.right, got.right);
            end
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic [263:0] s_tdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  m_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_wdata;

    torque_scoreboard sb;
    int  cycle_count;
    bit  calm;

    diff_drive_base_pd_torque #(.TRIG_TABLE_BITS(TRIG_BITS)) uut (.*);

    // clock
    always begin
        aclk = 1'b0; #10;
        aclk = 1'b1; #10;
    end

    initial begin
        sb = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        cycle_count = 0;
        calm = 1'b0;
    end

    // receiver: random stalls, checks on accepted results
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_result(torque_t'(m_tdata));
            m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 34);
        end
    end

    // run guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("diff_drive_base_pd_torque_test NOT OK");
            $finish;
        end
    end

    // one write, then the enable is dropped before the task returns
    task automatic write_reg(ddpd_pkg::cfg_index_t idx, logic [31:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, v);
        @(posedge aclk);
    endtask

    // holds valid until the handshake, idling at random before it;
    // valid stays high afterwards so items can follow back to back
    task automatic send_item(pose_item_t it);
        while (!calm && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {25'b0, it};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_item(it);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    function automatic logic signed [18:0] rand_heading();
        return 19'(int'($urandom_range(411774)) - 205887);
    endfunction

    function automatic pose_item_t rand_item(bit full_range);
        pose_item_t it;
        it.target_x = $urandom; it.target_y = $urandom;
        it.pose_x = $urandom; it.pose_y = $urandom;
        it.speed_x = $urandom; it.speed_y = $urandom; it.turn_rate = $urandom;
        if (!full_range) begin
            // realistic magnitudes keep the law away from saturation
            it.target_x = 32'(signed'(it.target_x) >>> $urandom_range(20, 4));
            it.target_y = 32'(signed'(it.target_y) >>> $urandom_range(20, 4));
            it.pose_x = 32'(signed'(it.pose_x) >>> $urandom_range(20, 4));
            it.pose_y = 32'(signed'(it.pose_y) >>> $urandom_range(20, 4));
            it.speed_x = 32'(signed'(it.speed_x) >>> $urandom_range(20, 8));
            it.speed_y = 32'(signed'(it.speed_y) >>> $urandom_range(20, 8));
            it.turn_rate = 32'(signed'(it.turn_rate) >>> $urandom_range(20, 8));
        end
        it.target_heading = rand_heading();
        it.pose_heading = rand_heading();
        return it;
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) begin
            calm = (i >= count / 3 && i < count / 3 + 60);
            send_item(rand_item($urandom_range(3) == 0));
        end
        calm = 1'b0;
    endtask

    initial begin
        pose_item_t it;
        logic signed [31:0] big [4] = '{32'sh7fffffff, -32'sh80000000, 32'sd0, -32'sd1};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes and heading wrap in both directions
        for (int k = 0; k < 4; k++) begin
            it.target_x = big[k]; it.target_y = big[3 - k];
            it.pose_x = big[(k + 1) % 4]; it.pose_y = big[(k + 2) % 4];
            it.speed_x = big[k]; it.speed_y = big[(k + 3) % 4];
            it.turn_rate = big[(k + 1) % 4];
            it.target_heading = k[0] ? 19'sd205887 : -19'sd205887;
            it.pose_heading = k[0] ? -19'sd205887 : 19'sd205887;
            send_item(it);
        end
        it = rand_item(0); it.target_heading = 19'sd200000; it.pose_heading = -19'sd200000;
        send_item(it);
        it = rand_item(0); it.target_heading = -19'sd200000; it.pose_heading = 19'sd200000;
        send_item(it);
        it = rand_item(0); it.target_heading = 19'sd205887; it.pose_heading = 19'sd0;
        send_item(it);
        for (int q = 0; q < 8; q++) begin
            it = rand_item(0);
            it.pose_heading = 19'(q * 51472 - 205887);
            send_item(it);
        end
        // sender holds off until everything is back
        drain();

        // passive mode with extreme gains
        write_reg(ddpd_pkg::REG_ACTUATE_ENABLE, 32'd0);
        write_reg(ddpd_pkg::REG_PASSIVE_KD_TRANSLATE, 32'hffffffff);
        write_reg(ddpd_pkg::REG_PASSIVE_KD_ROTATE, 32'hffffffff);
        for (int k = 0; k < 4; k++) begin
            it = rand_item(k[0]);
            it.speed_x = big[k]; it.turn_rate = big[3 - k];
            send_item(it);
        end
        random_phase(300);
        drain();

        // full law, all gains maximal
        write_reg(ddpd_pkg::REG_ACTUATE_ENABLE, 32'hfffffffd);
        write_reg(ddpd_pkg::REG_KP_TRANSLATE, 32'hffffffff);
        write_reg(ddpd_pkg::REG_KD_TRANSLATE, 32'hffffffff);
        write_reg(ddpd_pkg::REG_KP_ROTATE, 32'hffffffff);
        write_reg(ddpd_pkg::REG_KD_ROTATE, 32'hffffffff);
        write_reg(ddpd_pkg::REG_HALF_INVERSE_AXLE, 32'hffffffff);
        random_phase(300);
        drain();

        // all active-mode gains and the axle factor zero
        write_reg(ddpd_pkg::REG_KP_TRANSLATE, 32'd0);
        write_reg(ddpd_pkg::REG_KD_TRANSLATE, 32'd0);
        write_reg(ddpd_pkg::REG_KP_ROTATE, 32'd0);
        write_reg(ddpd_pkg::REG_KD_ROTATE, 32'd0);
        write_reg(ddpd_pkg::REG_HALF_INVERSE_AXLE, 32'd0);
        random_phase(200);
        drain();

        // random gain sets
        for (int p = 0; p < 4; p++) begin
            write_reg(ddpd_pkg::REG_KP_TRANSLATE, $urandom_range(32'h00ffffff));
            write_reg(ddpd_pkg::REG_KD_TRANSLATE, $urandom_range(32'h003fffff));
            write_reg(ddpd_pkg::REG_PASSIVE_KD_TRANSLATE, $urandom);
            write_reg(ddpd_pkg::REG_KP_ROTATE, $urandom_range(32'h00ffffff));
            write_reg(ddpd_pkg::REG_KD_ROTATE, $urandom_range(32'h003fffff));
            write_reg(ddpd_pkg::REG_PASSIVE_KD_ROTATE, $urandom);
            write_reg(ddpd_pkg::REG_ACTUATE_ENABLE, 32'($urandom_range(3) != 0));
            write_reg(ddpd_pkg::REG_HALF_INVERSE_AXLE, $urandom_range(32'h0003ffff));
            random_phase(280);
            drain();
        end

        if (sb.fails == 0) begin
            $display("diff_drive_base_pd_torque_test OK");
        end else begin
            $display("diff_drive_base_pd_torque_test NOT OK");
        end
        $finish;
    end

endmodule
